@@ rtl/core/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key-value cache
// operation codes, controller states, command group and port widths
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CAP_W  = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 104;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // access operations
  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET    = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_EXISTS = 2'd3
  } func_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MATCH  = 2'd1,
    ST_UPDATE = 2'd2
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture an accepted input item
    logic match_en;  // register the lookup results
    logic commit;    // update the entries and load the output register
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl: access sequencer
// steps each item through lookup and update, owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output lkvc_pkg::cmd_t     cmd_o
);

  lkvc_pkg::state_e state_q, state_d;
  logic             m_tvalid_q, m_tvalid_d;
  logic             out_free;

  // output register can take a new item this cycle
  assign out_free = !m_tvalid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (s_tvalid_i) state_d = lkvc_pkg::ST_MATCH;
      end
      lkvc_pkg::ST_MATCH: begin
        state_d = lkvc_pkg::ST_UPDATE;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = s_tvalid_i ? lkvc_pkg::ST_MATCH : lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    s_tready_o     = 1'b0;
    cmd_o.match_en = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
      end
      lkvc_pkg::ST_MATCH: begin
        cmd_o.match_en = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        s_tready_o   = out_free;
        cmd_o.commit = out_free;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
    cmd_o.load_in = s_tvalid_i && s_tready_o;
  end

  // output valid flag
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (cmd_o.commit) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lkvc_pkg::ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;

endmodule

`default_nettype wire

@@ rtl/core/lkvc_dp.sv @@
// ----------------------------------------------------------------------------
// lkvc_dp: entry store and lookup datapath
// recency-ordered slots with parallel key match, shift-based reordering
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_dp #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lkvc_pkg::cmd_t                cmd_i,
  input  wire logic [lkvc_pkg::IN_W-1:0]     s_tdata_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]    cfg_data_i,
  output logic      [lkvc_pkg::OUT_W-1:0]    m_tdata_o
);

  localparam int unsigned DW   = lkvc_pkg::DATA_W;
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > lkvc_pkg::CAP_W) ? CntW : lkvc_pkg::CAP_W;
  localparam int unsigned PadW = lkvc_pkg::OUT_W - (3 * DW + 2);

  // configuration and occupancy
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [CntW-1:0]            count_q, count_d;

  // captured input item
  lkvc_pkg::func_e in_func_q;
  logic [DW-1:0]   in_key_q, in_val_q;

  // entry slots, slot 0 most recent
  logic [DW-1:0] key_q [MAX_ENTRIES];
  logic [DW-1:0] val_q [MAX_ENTRIES];

  // lookup results
  logic [MAX_ENTRIES-1:0] slot_valid, slot_match, slot_last;
  logic                   hit, evict;
  logic [IdxW-1:0]        match_idx;
  logic [DW-1:0]          match_val, last_key, last_val;
  logic [CntW-1:0]        front_lim;
  logic [CmpW-1:0]        cnt_ext, cap_ext, max_ext, eff_cap;

  // registered lookup results
  logic            hit_q, evict_q;
  logic [IdxW-1:0] idx_q;
  logic [DW-1:0]   rv_q, ek_q, evv_q;
  logic [CntW-1:0] lim_q;

  // output register
  logic [lkvc_pkg::OUT_W-1:0] out_q;

  // operation decode for the update cycle
  logic is_get, is_put, is_remove, do_front, do_drop;
  logic [DW-1:0] front_val;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_func_q <= lkvc_pkg::func_e'(s_tdata_i[1:0]);
      in_key_q  <= s_tdata_i[DW+1:2];
      in_val_q  <= s_tdata_i[2*DW+1:DW+2];
    end
  end

  // per-slot valid, match and last flags
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_flags
    assign slot_valid[i] = CntW'(i) < count_q;
    assign slot_match[i] = slot_valid[i] && (key_q[i] == in_key_q);
    assign slot_last[i]  = CntW'(i + 1) == count_q;
  end

  // one-hot select of match and last slot
  always_comb begin
    match_idx = '0;
    match_val = '0;
    last_key  = '0;
    last_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_match[i]) match_idx = match_idx | IdxW'(i);
      match_val = match_val | ({DW{slot_match[i]}} & val_q[i]);
      last_key  = last_key  | ({DW{slot_last[i]}} & key_q[i]);
      last_val  = last_val  | ({DW{slot_last[i]}} & val_q[i]);
    end
  end

  // effective capacity and eviction decision
  assign cnt_ext = CmpW'(count_q);
  assign cap_ext = CmpW'(cap_q);
  assign max_ext = CmpW'(MAX_ENTRIES);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hit   = |slot_match;
  assign evict = (in_func_q == lkvc_pkg::FUNC_PUT) && !hit &&
                 (count_q != '0) && (cnt_ext >= eff_cap);

  // highest slot that moves down when an entry goes to the front
  always_comb begin
    if (hit) begin
      front_lim = CntW'(match_idx);
    end else if (evict) begin
      front_lim = count_q - CntW'(1);
    end else begin
      front_lim = count_q;
    end
  end

  // lookup result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_en) begin
      hit_q   <= hit;
      evict_q <= evict;
      idx_q   <= match_idx;
      rv_q    <= match_val;
      ek_q    <= last_key;
      evv_q   <= last_val;
      lim_q   <= front_lim;
    end
  end

  // update decode
  assign is_get    = in_func_q == lkvc_pkg::FUNC_GET;
  assign is_put    = in_func_q == lkvc_pkg::FUNC_PUT;
  assign is_remove = in_func_q == lkvc_pkg::FUNC_REMOVE;
  assign do_front  = (is_get && hit_q) || is_put;
  assign do_drop   = is_remove && hit_q;
  assign front_val = is_put ? in_val_q : rv_q;

  // slot update: shift down toward the front entry, or up over a removed one
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_slot
    logic [DW-1:0] up_key, up_val, dn_key, dn_val;
    logic          take_up, take_dn;

    if (i == 0) begin : g_head
      assign up_key = in_key_q;
      assign up_val = front_val;
    end else begin : g_body
      assign up_key = key_q[i-1];
      assign up_val = val_q[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign dn_key = key_q[i];
      assign dn_val = val_q[i];
    end else begin : g_inner
      assign dn_key = key_q[i+1];
      assign dn_val = val_q[i+1];
    end

    assign take_up = do_front && (CntW'(i) <= lim_q);
    assign take_dn = do_drop && (CntW'(i) >= CntW'(idx_q)) && (CntW'(i + 1) < count_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (take_up) begin
          key_q[i] <= up_key;
          val_q[i] <= up_val;
        end else if (take_dn) begin
          key_q[i] <= dn_key;
          val_q[i] <= dn_val;
        end
      end
    end
  end

  // occupancy
  always_comb begin
    count_d = count_q;
    if (is_put && !hit_q && !evict_q) begin
      count_d = count_q + CntW'(1);
    end else if (do_drop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= {{PadW{1'b0}},
                (evict_q ? evv_q : {DW{1'b0}}),
                (evict_q ? ek_q : {DW{1'b0}}),
                evict_q,
                ((is_get && hit_q) ? rv_q : {DW{1'b0}}),
                hit_q};
    end
  end

  assign m_tdata_o = out_q;

endmodule

`default_nettype wire

@@ rtl/core/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative lru key-value cache
// get, put, remove and exists accesses on a recency-ordered entry store
// ----------------------------------------------------------------------------
// an accepted item passes the match state and then the update state before its
//   result is valid, and waits longer while a waiting result holds the update state
// a new item is taken in the update state of the previous one when the output
//   register is free; the match and the reorder and write-back share the entry store
// reset: entries empty, capacity 16, no result pending; no clearing pass
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [1:0] func, [33:2] key, [65:34] value, [71:66] zero
  input  wire logic [lkvc_pkg::IN_W-1:0]     s_tdata,
  // result items
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key,
  // [97:66] evicted_value, [103:98] zero
  output logic      [lkvc_pkg::OUT_W-1:0]    m_tdata,
  // capacity_in_use write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0]    cfg_data
);

  lkvc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .cmd_o      (cmd)
  );

  lkvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .s_tdata_i   (s_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data),
    .m_tdata_o   (m_tdata)
  );

`ifndef SYNTH
  // an update always leaves a result in the output register
  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_tvalid)
    else $error("commit did not produce a result");

  // an accepted item is looked up in the next cycle
  a_load_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |=> cmd.match_en)
    else $error("accepted item skipped the match cycle");

  // lookup and update never overlap
  a_match_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.match_en && cmd.commit))
    else $error("match and commit in the same cycle");

  // no item is accepted during the match cycle
  a_no_load_in_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.match_en |-> !s_tready)
    else $error("input ready during match");
`endif

endmodule

`default_nettype wire

@@ tb/lru_key_value_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking testbench of the lru key-value cache
// drives get, put, remove and exists items through the input stream, predicts
// each result with a behavioral lru store and compares every result item
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned KEY_POOL_N  = 24;

  // one result item, fields as the cache reports them
  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] read_value;
    logic                        evicted;
    logic [lkvc_pkg::DATA_W-1:0] evicted_key;
    logic [lkvc_pkg::DATA_W-1:0] evicted_value;
  } access_result_t;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  // [1:0] func, [33:2] key, [65:34] value, [71:66] zero
  logic [lkvc_pkg::IN_W-1:0]   s_tdata   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key,
  // [97:66] evicted_value, [103:98] zero
  logic [lkvc_pkg::OUT_W-1:0]  m_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0]  cfg_data  = '0;

  // predicted store contents, slot 0 most recent
  logic [lkvc_pkg::DATA_W-1:0] lru_key [MAX_ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] lru_val [MAX_ENTRIES];
  int                          lru_used;
  logic [lkvc_pkg::CAP_W-1:0]  capacity_reg;

  access_result_t              pending_results[$];
  logic [lkvc_pkg::DATA_W-1:0] key_pool [KEY_POOL_N];
  int                          error_count  = 0;
  int unsigned                 cycle_count  = 0;
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_idle_pct = 0;
  int unsigned                 stall_cycles  = 0;

  lru_key_value_cache #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_key_value_cache: mismatch");
      $finish;
    end
  end

  // move slot s to the front, shifting younger slots back
  function automatic void promote_slot(int s);
    logic [lkvc_pkg::DATA_W-1:0] k;
    logic [lkvc_pkg::DATA_W-1:0] v;
    k = lru_key[s];
    v = lru_val[s];
    for (int i = s; i > 0; i--) begin
      lru_key[i] = lru_key[i-1];
      lru_val[i] = lru_val[i-1];
    end
    lru_key[0] = k;
    lru_val[0] = v;
  endfunction

  // expected result of one access, updating the predicted store
  function automatic access_result_t predict_access(lkvc_pkg::func_e op,
                                                    logic [lkvc_pkg::DATA_W-1:0] k,
                                                    logic [lkvc_pkg::DATA_W-1:0] v);
    access_result_t r;
    int slot;
    int limit;
    r = '0;
    slot = lru_used;
    for (int i = 0; i < lru_used; i++)
      if (lru_key[i] == k && slot == lru_used) slot = i;
    r.hit = (slot < lru_used);
    limit = (capacity_reg == 0) ? 1 :
            (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
    case (op)
      lkvc_pkg::FUNC_GET: begin
        if (r.hit) begin
          r.read_value = lru_val[slot];
          promote_slot(slot);
        end
      end
      lkvc_pkg::FUNC_PUT: begin
        if (r.hit) begin
          lru_val[slot] = v;
          promote_slot(slot);
        end else begin
          // full, or capacity lowered below occupancy: drop the oldest
          if (lru_used >= limit && lru_used > 0) begin
            r.evicted       = 1'b1;
            r.evicted_key   = lru_key[lru_used-1];
            r.evicted_value = lru_val[lru_used-1];
            lru_used--;
          end
          if (lru_used < MAX_ENTRIES) begin
            for (int i = lru_used; i > 0; i--) begin
              lru_key[i] = lru_key[i-1];
              lru_val[i] = lru_val[i-1];
            end
            lru_key[0] = k;
            lru_val[0] = v;
            lru_used++;
          end
        end
      end
      lkvc_pkg::FUNC_REMOVE: begin
        if (r.hit) begin
          for (int i = slot; i < lru_used - 1; i++) begin
            lru_key[i] = lru_key[i+1];
            lru_val[i] = lru_val[i+1];
          end
          lru_used--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_access(lkvc_pkg::func_e op, logic [lkvc_pkg::DATA_W-1:0] k,
                             logic [lkvc_pkg::DATA_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, v, k, op};
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(predict_access(op, k, v));
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    capacity_reg = cap;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic lkvc_pkg::func_e pick_func();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return lkvc_pkg::FUNC_GET;
    if (r < 65) return lkvc_pkg::FUNC_PUT;
    if (r < 80) return lkvc_pkg::FUNC_REMOVE;
    return lkvc_pkg::FUNC_EXISTS;
  endfunction

  // mostly reused keys so that hits and evictions are common
  function automatic logic [lkvc_pkg::DATA_W-1:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(KEY_POOL_N-1)];
    return $urandom;
  endfunction

  // receiver ready, with an optional long hold-off
  always @(posedge clk_i) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic [lkvc_pkg::DATA_W-1:0] exp_v,
                             logic [lkvc_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    access_result_t exp_r;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %h", $time, m_tdata);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(m_tdata[0]));
        check_field("read_value", exp_r.read_value, m_tdata[32:1]);
        check_field("evicted", 32'(exp_r.evicted), 32'(m_tdata[33]));
        check_field("evicted_key", exp_r.evicted_key, m_tdata[65:34]);
        check_field("evicted_value", exp_r.evicted_value, m_tdata[97:66]);
      end
    end
  end

  // every operation on hits and misses, field extremes
  task automatic test_directed_access();
    send_idle_pct = 25;
    recv_idle_pct = 53;
    send_access(lkvc_pkg::FUNC_GET,    32'h8000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_EXISTS, 32'h8000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_PUT,    32'h8000_0000, 32'h7fff_ffff);
    send_access(lkvc_pkg::FUNC_PUT,    32'h7fff_ffff, 32'h8000_0000);
    send_access(lkvc_pkg::FUNC_PUT,    32'h0000_0000, 32'hffff_ffff);
    send_access(lkvc_pkg::FUNC_PUT,    32'hffff_ffff, 32'h0000_0000);
    send_access(lkvc_pkg::FUNC_GET,    32'h8000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_EXISTS, 32'h0000_0000, 32'h0);
    // put on a present key overwrites without eviction
    send_access(lkvc_pkg::FUNC_PUT,    32'h7fff_ffff, 32'h1234_5678);
    send_access(lkvc_pkg::FUNC_GET,    32'h7fff_ffff, 32'hffff_ffff);
    send_access(lkvc_pkg::FUNC_REMOVE, 32'h0000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_GET,    32'h0000_0000, 32'h0);
    send_access(lkvc_pkg::FUNC_GET,    32'hffff_ffff, 32'hdead_beef);
    wait_drained();
  endtask

  // capacity zero acts as one, and is below the current occupancy
  task automatic test_capacity_edges();
    write_capacity(5'd0);
    send_access(lkvc_pkg::FUNC_PUT,    32'h0000_0011, 32'haaaa_5555);
    send_access(lkvc_pkg::FUNC_PUT,    32'h0000_0022, 32'h5555_aaaa);
    send_access(lkvc_pkg::FUNC_GET,    32'h0000_0011, 32'h0);
    send_access(lkvc_pkg::FUNC_EXISTS, 32'h0000_0022, 32'h0);
    wait_drained();
    // above the entry count, acts as the full store
    write_capacity(5'd31);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_full_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles <= 300;
    repeat (40) send_access(lkvc_pkg::FUNC_PUT, $urandom, $urandom);
    wait_drained();
  endtask

  // random accesses under three idling patterns, capacity changed between blocks
  task automatic test_random_mix();
    logic [lkvc_pkg::CAP_W-1:0] cap;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 25 : (p == 1) ? 53 : 0;
      recv_idle_pct = (p == 0) ? 53 : (p == 1) ? 25 : 0;
      for (int b = 0; b < 5; b++) begin
        wait_drained();
        cap = ($urandom_range(1) != 0) ? lkvc_pkg::CAP_W'($urandom_range(31)) :
                                         lkvc_pkg::CAP_W'($urandom_range(1, 6));
        write_capacity(cap);
        repeat (100) send_access(pick_func(), pick_key(), $urandom);
      end
    end
    wait_drained();
    write_capacity(lkvc_pkg::CAP_RESET);
  endtask

  initial begin
    lru_used     = 0;
    capacity_reg = lkvc_pkg::CAP_RESET;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lru_key[i] = '0;
      lru_val[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_access();
    test_capacity_edges();
    test_full_backpressure();
    test_random_mix();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0)
      $display("lru_key_value_cache: match");
    else
      $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lkvc_dp.sv
rtl/core/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
